// ===== hw/rtl/sqvt_pkg.sv =====
// ----------------------------------------------------------------------------
// sqvt_pkg: shared types and constants
// Request and result structs, register indexes, divider sizing and angle
// constants for the sprite quad vertex transform unit.
// ----------------------------------------------------------------------------
package sqvt_pkg;

	typedef struct packed {
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] size_w;
		logic signed [15:0] size_h;
		logic signed [15:0] tex_x;
		logic signed [15:0] tex_y;
		logic signed [15:0] tex_w;
		logic signed [15:0] tex_h;
		logic [15:0]        turn_angle;
		logic [31:0]        color_rgba;
	} sprite_req_t;

	typedef struct packed {
		logic [1:0]         corner;
		logic signed [15:0] ndc_x;
		logic signed [15:0] ndc_y;
		logic signed [15:0] tex_u;
		logic signed [15:0] tex_v;
		logic [31:0]        vertex_color;
		logic               last_corner;
	} vertex_res_t;

	// per-vertex sideband that rides along the pipeline
	typedef struct packed {
		logic [1:0]  corner;
		logic        last;
		logic [31:0] color;
		logic [3:0]  lo;    // lane saturates low  (x, y, u, v)
		logic [3:0]  hi;    // lane saturates high
	} side_t;

	localparam int CFG_IDX_W = 4;
	localparam logic [CFG_IDX_W-1:0] REG_VIEWPORT_W = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VIEWPORT_H = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TEXTURE_W  = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TEXTURE_H  = 4'd3;

	localparam int REG_W      = 14;
	localparam int QUOT_W     = 16;
	localparam int DIV_STEPS  = 2;
	localparam int DIV_STAGES = QUOT_W / DIV_STEPS;
	localparam int NUM_W      = 36;
	localparam int DEN_W      = 19;
	localparam int WIDE_W     = 40;

	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint unsigned ONE_Q30     = 64'd1073741824;

endpackage

// ===== hw/rtl/sqvt_div.sv =====
// ----------------------------------------------------------------------------
// sqvt_div: pipelined restoring divider
// Unsigned 16-bit quotient, two quotient bits per stage, one new operand
// every cycle. Numerator must stay below den << 16.
// ----------------------------------------------------------------------------
module sqvt_div (
	input  logic                          clk,
	input  logic [sqvt_pkg::NUM_W-1:0]    num,
	input  logic [sqvt_pkg::DEN_W-1:0]    den,
	output logic [sqvt_pkg::QUOT_W-1:0]   quot
);

	localparam int NS = sqvt_pkg::DIV_STAGES;

	logic [sqvt_pkg::NUM_W-1:0]  rem_s   [NS];
	logic [sqvt_pkg::QUOT_W-1:0] quo_s   [NS];
	logic [sqvt_pkg::NUM_W-1:0]  rem_in  [NS];
	logic [sqvt_pkg::QUOT_W-1:0] quo_in  [NS];
	logic [sqvt_pkg::NUM_W-1:0]  rem_nxt [NS];
	logic [sqvt_pkg::QUOT_W-1:0] quo_nxt [NS];

	assign rem_in[0] = num;
	assign quo_in[0] = '0;

	for (genvar g = 0; g < NS; g++) begin : g_stage
		localparam int B0 = sqvt_pkg::QUOT_W - 1 - g * sqvt_pkg::DIV_STEPS;

		if (g > 0) begin : g_link
			assign rem_in[g] = rem_s[g-1];
			assign quo_in[g] = quo_s[g-1];
		end

		always_comb begin
			logic [sqvt_pkg::NUM_W-1:0]  r;
			logic [sqvt_pkg::QUOT_W-1:0] qv;
			logic [sqvt_pkg::NUM_W-1:0]  sh;
			r  = rem_in[g];
			qv = quo_in[g];
			for (int j = 0; j < sqvt_pkg::DIV_STEPS; j++) begin
				sh = sqvt_pkg::NUM_W'(den) << (B0 - j);
				if (r >= sh) begin
					r = r - sh;
					qv[B0-j] = 1'b1;
				end
			end
			rem_nxt[g] = r;
			quo_nxt[g] = qv;
		end

		always_ff @(posedge clk) begin
			rem_s[g] <= rem_nxt[g];
			quo_s[g] <= quo_nxt[g];
		end
	end

	assign quot = quo_s[NS-1];

endmodule

// ===== hw/rtl/sprite_quad_vertex_transform_unit.sv =====
// ----------------------------------------------------------------------------
// sprite_quad_vertex_transform_unit: rotated sprite quad to NDC vertices
// Expands one sprite request into four triangle-strip vertices, rotates them
// about the sprite center and maps them to saturated Q2.14 NDC and texel
// coordinates.
// ----------------------------------------------------------------------------
//
// channel   direction  handshake                    payload
// request   in         start & !busy                sprite (sprite_req_t)
// config    in         cfg_valid & cfg_ready        cfg_index, cfg_data
// result    out        result_valid, one-cycle      result (vertex_res_t)
//
// The issue counter sends one vertex per cycle; busy drops as the last corner
// issues, so the next request is taken then. Corner 0 reaches the result
// ports via 4 front stages, 8 divider stages and the output register; the
// rest follow back to back. No back-pressure on results; the pipeline never
// stalls. arst_n clears valid bits and issue counter, loads config defaults.
// The user makes config writes only idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module sprite_quad_vertex_transform_unit #(
	parameter int SINE_TABLE_DEPTH = 1024
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  sqvt_pkg::sprite_req_t                sprite,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [sqvt_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [sqvt_pkg::REG_W-1:0]           cfg_data,
	output logic                                 result_valid,
	output sqvt_pkg::vertex_res_t                result
);

	localparam int IW = $clog2(SINE_TABLE_DEPTH);
	localparam int QW = IW + 2;
	localparam int NS = sqvt_pkg::DIV_STAGES;
	localparam int WW = sqvt_pkg::WIDE_W;

	// ---------------- config registers ----------------
	logic [sqvt_pkg::REG_W-1:0] vw_q, vh_q, tw_q, th_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vw_q <= 14'd1280;
			vh_q <= 14'd720;
			tw_q <= 14'd256;
			th_q <= 14'd256;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				sqvt_pkg::REG_VIEWPORT_W: vw_q <= cfg_data;
				sqvt_pkg::REG_VIEWPORT_H: vh_q <= cfg_data;
				sqvt_pkg::REG_TEXTURE_W:  tw_q <= cfg_data;
				sqvt_pkg::REG_TEXTURE_H:  th_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// divisors, zero register treated as one
	logic [sqvt_pkg::REG_W-1:0] vw_nz, vh_nz, tw_nz, th_nz;
	logic [sqvt_pkg::DEN_W-1:0] den_x, den_y, den_u, den_v;

	assign vw_nz = (vw_q == '0) ? 14'd1 : vw_q;
	assign vh_nz = (vh_q == '0) ? 14'd1 : vh_q;
	assign tw_nz = (tw_q == '0) ? 14'd1 : tw_q;
	assign th_nz = (th_q == '0) ? 14'd1 : th_q;
	assign den_x = {vw_nz, 5'b0};
	assign den_y = {vh_nz, 5'b0};
	assign den_u = {4'b0, tw_nz, 1'b0};
	assign den_v = {4'b0, th_nz, 1'b0};

	logic signed [WW-1:0] dxe, dye, due, dve;
	assign dxe = signed'(WW'(den_x));
	assign dye = signed'(WW'(den_y));
	assign due = signed'(WW'(den_u));
	assign dve = signed'(WW'(den_v));

	// ---------------- request hold and vertex issue ----------------
	sqvt_pkg::sprite_req_t hold_q;
	logic                  active_q;
	logic [1:0]            cnt_q;
	logic                  accept;

	assign busy   = active_q && (cnt_q != 2'd3);
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cnt_q    <= '0;
		end else if (accept) begin
			active_q <= 1'b1;
			cnt_q    <= '0;
		end else if (active_q) begin
			if (cnt_q == 2'd3) active_q <= 1'b0;
			else               cnt_q    <= cnt_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) hold_q <= sprite;
	end

	// ---------------- stage 1: corner geometry, table index ----------------
	logic [31:0]   turn_prod;
	logic [IW-1:0] idx_c;
	logic [QW-1:0] four_i;
	logic [1:0]    quad_c;

	assign turn_prod = 32'(hold_q.turn_angle) * 32'(SINE_TABLE_DEPTH);
	assign idx_c     = turn_prod[16+IW-1:16];
	assign four_i    = {idx_c, 2'b00};

	always_comb begin
		if (four_i >= QW'(3 * SINE_TABLE_DEPTH))      quad_c = 2'd3;
		else if (four_i >= QW'(2 * SINE_TABLE_DEPTH)) quad_c = 2'd2;
		else if (four_i >= QW'(SINE_TABLE_DEPTH))     quad_c = 2'd1;
		else                                          quad_c = 2'd0;
	end

	logic                 v_s1;
	sqvt_pkg::side_t      side_s1;
	logic [IW-1:0]        idx_s1;
	logic [1:0]           quad_s1;
	logic signed [17:0]   cx_s1, cy_s1;
	logic signed [16:0]   dx_s1, dy_s1, tu_s1, tv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else         v_s1 <= active_q;
	end

	always_ff @(posedge clk) begin
		side_s1.corner <= cnt_q;
		side_s1.last   <= (cnt_q == 2'd3);
		side_s1.color  <= hold_q.color_rgba;
		side_s1.lo     <= '0;
		side_s1.hi     <= '0;
		idx_s1         <= idx_c;
		quad_s1        <= quad_c;
		cx_s1 <= (18'(hold_q.pos_x) <<< 1) + 18'(hold_q.size_w);
		cy_s1 <= (18'(hold_q.pos_y) <<< 1) + 18'(hold_q.size_h);
		dx_s1 <= cnt_q[0] ? 17'(hold_q.size_w) : -17'(hold_q.size_w);
		dy_s1 <= cnt_q[1] ? 17'(hold_q.size_h) : -17'(hold_q.size_h);
		tu_s1 <= cnt_q[0] ? 17'(hold_q.tex_x) + 17'(hold_q.tex_w) : 17'(hold_q.tex_x);
		tv_s1 <= cnt_q[1] ? 17'(hold_q.tex_y) + 17'(hold_q.tex_h) : 17'(hold_q.tex_y);
	end

	// ---------------- stage 2: sine / cosine table ----------------
	logic [14:0] sin_rom [SINE_TABLE_DEPTH];
	logic [14:0] cos_rom [SINE_TABLE_DEPTH];

	// table built at elaboration: 8-term Taylor sums in Q30, rounded to Q1.14
	for (genvar gi = 0; gi < SINE_TABLE_DEPTH; gi++) begin : g_rom
		localparam longint unsigned QI = longint'((4 * gi) / SINE_TABLE_DEPTH);
		localparam longint unsigned RI = longint'(4 * gi) - QI * longint'(SINE_TABLE_DEPTH);
		localparam longint unsigned AI = (RI * sqvt_pkg::HALF_PI_Q30) /
			longint'(SINE_TABLE_DEPTH);
		localparam longint unsigned A2 = (AI * AI) >> 30;
		localparam longint unsigned S1 = ((AI * A2) >> 30) / 64'd6;
		localparam longint unsigned S2 = ((S1 * A2) >> 30) / 64'd20;
		localparam longint unsigned S3 = ((S2 * A2) >> 30) / 64'd42;
		localparam longint unsigned S4 = ((S3 * A2) >> 30) / 64'd72;
		localparam longint unsigned S5 = ((S4 * A2) >> 30) / 64'd110;
		localparam longint unsigned S6 = ((S5 * A2) >> 30) / 64'd156;
		localparam longint unsigned S7 = ((S6 * A2) >> 30) / 64'd210;
		localparam longint unsigned C1 = ((sqvt_pkg::ONE_Q30 * A2) >> 30) / 64'd2;
		localparam longint unsigned C2 = ((C1 * A2) >> 30) / 64'd12;
		localparam longint unsigned C3 = ((C2 * A2) >> 30) / 64'd30;
		localparam longint unsigned C4 = ((C3 * A2) >> 30) / 64'd56;
		localparam longint unsigned C5 = ((C4 * A2) >> 30) / 64'd90;
		localparam longint unsigned C6 = ((C5 * A2) >> 30) / 64'd132;
		localparam longint unsigned C7 = ((C6 * A2) >> 30) / 64'd182;
		localparam longint SSUM = longint'(AI) - longint'(S1) + longint'(S2) -
			longint'(S3) + longint'(S4) - longint'(S5) + longint'(S6) - longint'(S7);
		localparam longint CSUM = longint'(sqvt_pkg::ONE_Q30) - longint'(C1) +
			longint'(C2) - longint'(C3) + longint'(C4) - longint'(C5) +
			longint'(C6) - longint'(C7);
		localparam longint SCLP = (SSUM < 0) ? 0 :
			((SSUM > longint'(sqvt_pkg::ONE_Q30)) ? longint'(sqvt_pkg::ONE_Q30) : SSUM);
		localparam longint CCLP = (CSUM < 0) ? 0 :
			((CSUM > longint'(sqvt_pkg::ONE_Q30)) ? longint'(sqvt_pkg::ONE_Q30) : CSUM);
		assign sin_rom[gi] = 15'((SCLP + 32768) >>> 16);
		assign cos_rom[gi] = 15'((CCLP + 32768) >>> 16);
	end

	logic                 v_s2;
	sqvt_pkg::side_t      side_s2;
	logic [1:0]           quad_s2;
	logic [14:0]          sa_s2, ca_s2;
	logic signed [17:0]   cx_s2, cy_s2;
	logic signed [16:0]   dx_s2, dy_s2, tu_s2, tv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else         v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		side_s2 <= side_s1;
		quad_s2 <= quad_s1;
		sa_s2   <= sin_rom[idx_s1];
		ca_s2   <= cos_rom[idx_s1];
		cx_s2   <= cx_s1;
		cy_s2   <= cy_s1;
		dx_s2   <= dx_s1;
		dy_s2   <= dy_s1;
		tu_s2   <= tu_s1;
		tv_s2   <= tv_s1;
	end

	// ---------------- stage 3: quadrant fold, products, texel numerators ----
	logic signed [15:0] sa_w, ca_w, s_c, c_c;

	assign sa_w = signed'(16'(sa_s2));
	assign ca_w = signed'(16'(ca_s2));

	always_comb begin
		case (quad_s2)
			2'd0:    begin s_c = sa_w;  c_c = ca_w;  end
			2'd1:    begin s_c = ca_w;  c_c = -sa_w; end
			2'd2:    begin s_c = -sa_w; c_c = -ca_w; end
			default: begin s_c = -ca_w; c_c = sa_w;  end
		endcase
	end

	// round_div: half divisor for rounding, q + 32768 bias for texel lanes
	logic signed [WW-1:0] nu_c, nv_c;
	assign nu_c = (WW'(tu_s2) <<< 11) + (due >>> 1) + (due <<< 15);
	assign nv_c = (WW'(tv_s2) <<< 11) + (dve >>> 1) + (dve <<< 15);

	logic                 v_s3;
	sqvt_pkg::side_t      side_s3;
	logic signed [17:0]   cx_s3, cy_s3;
	logic signed [32:0]   pxc_s3, pys_s3, pxs_s3, pyc_s3;
	logic signed [WW-1:0] nu_s3, nv_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else         v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		side_s3 <= side_s2;
		cx_s3   <= cx_s2;
		cy_s3   <= cy_s2;
		pxc_s3  <= 33'(dx_s2) * 33'(c_c);
		pys_s3  <= 33'(dy_s2) * 33'(s_c);
		pxs_s3  <= 33'(dx_s2) * 33'(s_c);
		pyc_s3  <= 33'(dy_s2) * 33'(c_c);
		nu_s3   <= nu_c;
		nv_s3   <= nv_c;
	end

	// ---------------- stage 4: rotation sum, divider operands ----------------
	// round_div: half divisor for rounding, q + 16384 bias for viewport lanes
	logic signed [WW-1:0] rx_c, ry_c, nx_c, ny_c;

	assign rx_c = (WW'(cx_s3) <<< 14) + WW'(pxc_s3) - WW'(pys_s3);
	assign ry_c = (WW'(cy_s3) <<< 14) + WW'(pxs_s3) + WW'(pyc_s3);
	assign nx_c = (rx_c <<< 1) + (dxe >>> 1) + (dxe <<< 14);
	assign ny_c = (ry_c <<< 1) + (dye >>> 1) + (dye <<< 14);

	logic [3:0] lo_c, hi_c;
	assign lo_c = {nv_s3[WW-1], nu_s3[WW-1], ny_c[WW-1], nx_c[WW-1]};
	assign hi_c = {!nv_s3[WW-1] && (nv_s3 >= (dve <<< 16)),
	               !nu_s3[WW-1] && (nu_s3 >= (due <<< 16)),
	               !ny_c[WW-1]  && (ny_c  >= (dye <<< 16)),
	               !nx_c[WW-1]  && (nx_c  >= (dxe <<< 16))};

	logic                        v_s4;
	sqvt_pkg::side_t             side_s4;
	logic [sqvt_pkg::NUM_W-1:0]  numx_s4, numy_s4, numu_s4, numv_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else         v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		side_s4.corner <= side_s3.corner;
		side_s4.last   <= side_s3.last;
		side_s4.color  <= side_s3.color;
		side_s4.lo     <= lo_c;
		side_s4.hi     <= hi_c;
		numx_s4        <= nx_c[sqvt_pkg::NUM_W-1:0];
		numy_s4        <= ny_c[sqvt_pkg::NUM_W-1:0];
		numu_s4        <= nu_s3[sqvt_pkg::NUM_W-1:0];
		numv_s4        <= nv_s3[sqvt_pkg::NUM_W-1:0];
	end

	// ---------------- divider lanes ----------------
	logic [sqvt_pkg::QUOT_W-1:0] qx, qy, qu, qv;

	sqvt_div u_div_x (.clk(clk), .num(numx_s4), .den(den_x), .quot(qx));
	sqvt_div u_div_y (.clk(clk), .num(numy_s4), .den(den_y), .quot(qy));
	sqvt_div u_div_u (.clk(clk), .num(numu_s4), .den(den_u), .quot(qu));
	sqvt_div u_div_v (.clk(clk), .num(numv_s4), .den(den_v), .quot(qv));

	// sideband delay matched to the divider
	logic            vd_s   [NS];
	sqvt_pkg::side_t sided_s[NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NS; k++) vd_s[k] <= 1'b0;
		end else begin
			vd_s[0] <= v_s4;
			for (int k = 1; k < NS; k++) vd_s[k] <= vd_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		sided_s[0] <= side_s4;
		for (int k = 1; k < NS; k++) sided_s[k] <= sided_s[k-1];
	end

	// ---------------- output stage: saturation and mapping ----------------
	sqvt_pkg::side_t sd;
	assign sd = sided_s[NS-1];

	logic signed [15:0] ox_c, oy_c, ou_c, ov_c;

	always_comb begin
		// x, u, v: value = q' - 32768
		if (sd.lo[0])      ox_c = -16'sd32768;
		else if (sd.hi[0]) ox_c = 16'sd32767;
		else               ox_c = signed'({~qx[15], qx[14:0]});

		if (sd.lo[2])      ou_c = -16'sd32768;
		else if (sd.hi[2]) ou_c = 16'sd32767;
		else               ou_c = signed'({~qu[15], qu[14:0]});

		if (sd.lo[3])      ov_c = -16'sd32768;
		else if (sd.hi[3]) ov_c = 16'sd32767;
		else               ov_c = signed'({~qv[15], qv[14:0]});

		// y: value = 32768 - q', flipped axis
		if (sd.lo[1] || (!sd.hi[1] && qy == '0)) oy_c = 16'sd32767;
		else if (sd.hi[1])                       oy_c = -16'sd32768;
		else                                     oy_c = signed'(16'(17'd32768 - 17'(qy)));
	end

	logic                  result_valid_q;
	sqvt_pkg::vertex_res_t result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) result_valid_q <= 1'b0;
		else         result_valid_q <= vd_s[NS-1];
	end

	always_ff @(posedge clk) begin
		result_q.corner       <= sd.corner;
		result_q.ndc_x        <= ox_c;
		result_q.ndc_y        <= oy_c;
		result_q.tex_u        <= ou_c;
		result_q.tex_v        <= ov_c;
		result_q.vertex_color <= sd.color;
		result_q.last_corner  <= sd.last;
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// ---------------- assertions ----------------
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("busy not raised after request accept");

	a_last_is_corner3: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.last_corner == (result.corner == 2'd3)))
		else $error("last_corner flag out of step with corner");

	a_corner_run: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.corner != 2'd0) |->
			($past(result_valid) && result.corner == 2'($past(result.corner) + 2'd1)))
		else $error("vertex run of a sprite broken");

endmodule
